[sv/csi_pkg.sv]
package csi_pkg;

    // Table geometry
    localparam int CAPACITY = 4;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DEPTH        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_MATCH_MIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_SQ_MAX  = 2'd2;

    // Register reset values
    localparam logic [30:0]        MIN_DEPTH_RST        = 31'd16;
    localparam logic signed [31:0] NORMAL_MATCH_MIN_RST = 32'sd1073634449;
    localparam logic [31:0]        DISTANCE_SQ_MAX_RST  = 32'd28147;

    // Request function codes
    localparam logic FUNC_OFFER = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_SHALLOW   = 3'd0,
        ST_DUP_KEEP  = 3'd1,
        ST_DUP_UPD   = 3'd2,
        ST_APPEND    = 3'd3,
        ST_REPLACE   = 3'd4,
        ST_FULL_KEEP = 3'd5,
        ST_CLEARED   = 3'd6
    } status_t;

    typedef struct packed {
        logic              func;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [31:0] depth;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [1:0] slot;
        logic [2:0] entry_count;
    } out_item_t;

    // One stored contact
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic signed [31:0] depth;
    } entry_t;

    // Table write control
    typedef struct packed {
        logic             en;
        logic             with_point;
        logic [IDX_W-1:0] idx;
    } tbl_wr_t;

    // Multiply-accumulate control and result
    typedef struct packed {
        logic clear;
        logic acc_dot;
        logic acc_dist;
    } mac_ctrl_t;

    typedef struct packed {
        logic dot_match;
        logic near;
    } mac_res_t;

endpackage

[sv/csi_table.sv]
module csi_table (
    input  logic                     aclk,
    input  csi_pkg::tbl_wr_t         wr,
    input  csi_pkg::entry_t          wr_data,
    input  logic [csi_pkg::IDX_W-1:0] rd_idx,
    output csi_pkg::entry_t          rd_data
);
    import csi_pkg::*;

    entry_t mem_reg [CAPACITY];

    // Write point only for new entries; normal and depth always
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            if (wr.with_point) begin
                mem_reg[wr.idx].px <= wr_data.px;
                mem_reg[wr.idx].py <= wr_data.py;
                mem_reg[wr.idx].pz <= wr_data.pz;
            end
            mem_reg[wr.idx].nx    <= wr_data.nx;
            mem_reg[wr.idx].ny    <= wr_data.ny;
            mem_reg[wr.idx].nz    <= wr_data.nz;
            mem_reg[wr.idx].depth <= wr_data.depth;
        end
    end

    assign rd_data = mem_reg[rd_idx];

endmodule

[sv/csi_mac.sv]
module csi_mac (
    input  logic                aclk,
    input  logic signed [31:0]  op_a,
    input  logic signed [31:0]  op_b,
    input  logic                op_far,
    input  csi_pkg::mac_ctrl_t  ctrl,
    input  logic signed [31:0]  normal_match_min,
    input  logic [31:0]         distance_sq_max,
    output csi_pkg::mac_res_t   res
);
    import csi_pkg::*;

    logic signed [31:0] op_a_reg;
    logic signed [31:0] op_b_reg;
    logic               far1_reg;
    logic signed [63:0] prod_reg;
    logic               far2_reg;
    logic signed [65:0] dot_acc_reg;
    logic [33:0]        dist_acc_reg;
    logic               far_acc_reg;

    logic signed [35:0] dot_shr;
    logic signed [31:0] dot_sat;

    // Register operands, then product, then accumulate
    always_ff @(posedge aclk) begin
        op_a_reg <= op_a;
        op_b_reg <= op_b;
        far1_reg <= op_far;
        prod_reg <= op_a_reg * op_b_reg;
        far2_reg <= far1_reg;
        if (ctrl.clear) begin
            dot_acc_reg  <= '0;
            dist_acc_reg <= '0;
            far_acc_reg  <= 1'b0;
        end else if (ctrl.acc_dot) begin
            dot_acc_reg <= dot_acc_reg + 66'(prod_reg);
        end else if (ctrl.acc_dist) begin
            dist_acc_reg <= dist_acc_reg + {2'b00, prod_reg[31:0]};
            far_acc_reg  <= far_acc_reg | far2_reg;
        end
    end

    // Floor shift to Q2.30 and saturate to 32 bits
    assign dot_shr = dot_acc_reg[65:30];

    always_comb begin
        if (dot_shr > 36'sh07FFFFFFF) begin
            dot_sat = 32'sh7FFFFFFF;
        end else if (dot_shr < -36'sh080000000) begin
            dot_sat = -32'sh80000000;
        end else begin
            dot_sat = dot_shr[31:0];
        end
    end

    assign res.dot_match = dot_sat > normal_match_min;
    assign res.near      = !far_acc_reg && (dist_acc_reg < {2'b00, distance_sq_max});

endmodule

[sv/contact_set_insert_core.sv]
// Contact table that keeps the deepest contacts, up to CAPACITY entries. A request
// either clears the table or offers a contact (point, normal, depth); each request
// gives exactly one result with a status, the slot written and the entry count. A
// clear, a too-shallow offer and an offer to an empty table show their result in the
// cycle after acceptance. Any other offer is compared against the stored entries in
// slot order through one shared 32x32 multiplier; for each entry the steps are three
// normal products, three squared point differences, a pipeline wait and a decision.
// The block takes one request at a time and is ready again the cycle after its
// result is taken. Configuration writes are taken in any cycle and must be made
// while the block is idle.
module contact_set_insert_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  csi_pkg::in_item_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output csi_pkg::out_item_t                m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [csi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                       cfg_data
);
    import csi_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } state_t;

    localparam logic [3:0] STEP_LAST = 4'd8;

    state_t             state_reg;
    logic [3:0]         step_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   wk_idx_reg;
    logic signed [31:0] wk_depth_reg;
    logic [CNT_W-1:0]   count_reg;
    in_item_t           in_reg;
    out_item_t          out_reg;
    logic               m_valid_reg;
    tbl_wr_t            wr_reg;

    logic [30:0]        min_depth_reg;
    logic signed [31:0] normal_match_min_reg;
    logic [31:0]        distance_sq_max_reg;

    entry_t             rd;
    entry_t             wr_data;
    mac_ctrl_t          ctrl;
    mac_res_t           res;
    logic signed [31:0] op_a;
    logic signed [31:0] op_b;
    logic               op_far;
    logic signed [31:0] p_st;
    logic signed [31:0] p_in;
    logic signed [32:0] diff;

    logic               shallow;
    logic               match;
    logic               deeper;
    logic               last_entry;
    logic               wk_take;
    logic [IDX_W-1:0]   wk_idx_n;
    logic signed [31:0] wk_depth_n;

    csi_table u_table (
        .aclk    (aclk),
        .wr      (wr_reg),
        .wr_data (wr_data),
        .rd_idx  (idx_reg),
        .rd_data (rd)
    );

    csi_mac u_mac (
        .aclk             (aclk),
        .op_a             (op_a),
        .op_b             (op_b),
        .op_far           (op_far),
        .ctrl             (ctrl),
        .normal_match_min (normal_match_min_reg),
        .distance_sq_max  (distance_sq_max_reg),
        .res              (res)
    );

    // Entry data comes from the held request
    always_comb begin
        wr_data.px    = in_reg.point_x;
        wr_data.py    = in_reg.point_y;
        wr_data.pz    = in_reg.point_z;
        wr_data.nx    = in_reg.normal_x;
        wr_data.ny    = in_reg.normal_y;
        wr_data.nz    = in_reg.normal_z;
        wr_data.depth = in_reg.depth;
    end

    // Select point axis for the difference terms
    always_comb begin
        case (step_reg)
            4'd4: begin
                p_st = rd.py;
                p_in = in_reg.point_y;
            end
            4'd5: begin
                p_st = rd.pz;
                p_in = in_reg.point_z;
            end
            default: begin
                p_st = rd.px;
                p_in = in_reg.point_x;
            end
        endcase
        diff = {p_st[31], p_st} - {p_in[31], p_in};
    end

    // Feed the shared multiplier: three normal products, then three squares.
    // A difference of 2^16 or more squares past any threshold: flag it far.
    always_comb begin
        op_a   = '0;
        op_b   = '0;
        op_far = 1'b0;
        case (step_reg)
            4'd0: begin
                op_a = rd.nx;
                op_b = in_reg.normal_x;
            end
            4'd1: begin
                op_a = rd.ny;
                op_b = in_reg.normal_y;
            end
            4'd2: begin
                op_a = rd.nz;
                op_b = in_reg.normal_z;
            end
            4'd3, 4'd4, 4'd5: begin
                op_a   = diff[31:0];
                op_b   = diff[31:0];
                op_far = !((diff <= 33'sd65535) && (diff >= -33'sd65535));
            end
            default: ;
        endcase
    end

    // Accumulate schedule trails operand issue through the operand and product registers
    always_comb begin
        ctrl.clear    = (state_reg == S_SCAN) && (step_reg == 4'd0);
        ctrl.acc_dot  = (state_reg == S_SCAN) && (step_reg >= 4'd2) && (step_reg <= 4'd4);
        ctrl.acc_dist = (state_reg == S_SCAN) && (step_reg >= 4'd5) && (step_reg <= 4'd7);
    end

    // Per-entry decision terms
    always_comb begin
        shallow    = $signed({s_data.depth[31], s_data.depth})
                     <= $signed({2'b00, min_depth_reg});
        match      = res.dot_match && res.near;
        deeper     = in_reg.depth > rd.depth;
        last_entry = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
        wk_take    = (idx_reg == '0) || (rd.depth < wk_depth_reg);
        wk_idx_n   = wk_take ? idx_reg : wk_idx_reg;
        wk_depth_n = wk_take ? rd.depth : wk_depth_reg;
    end

    // Sequencer, configuration registers and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg            <= S_IDLE;
            step_reg             <= '0;
            count_reg            <= '0;
            m_valid_reg          <= 1'b0;
            wr_reg               <= '0;
            min_depth_reg        <= MIN_DEPTH_RST;
            normal_match_min_reg <= NORMAL_MATCH_MIN_RST;
            distance_sq_max_reg  <= DISTANCE_SQ_MAX_RST;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_MIN_DEPTH:        min_depth_reg        <= cfg_data[30:0];
                    CFG_NORMAL_MATCH_MIN: normal_match_min_reg <= cfg_data;
                    CFG_DISTANCE_SQ_MAX:  distance_sq_max_reg  <= cfg_data;
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        in_reg <= s_data;
                        if (s_data.func == FUNC_CLEAR) begin
                            count_reg           <= '0;
                            out_reg.status      <= ST_CLEARED;
                            out_reg.slot        <= '0;
                            out_reg.entry_count <= '0;
                            m_valid_reg         <= 1'b1;
                            state_reg           <= S_RESP;
                        end else if (shallow) begin
                            out_reg.status      <= ST_SHALLOW;
                            out_reg.slot        <= '0;
                            out_reg.entry_count <= 3'(count_reg);
                            m_valid_reg         <= 1'b1;
                            state_reg           <= S_RESP;
                        end else if (count_reg == '0) begin
                            wr_reg              <= '{en: 1'b1, with_point: 1'b1, idx: '0};
                            count_reg           <= CNT_W'(1);
                            out_reg.status      <= ST_APPEND;
                            out_reg.slot        <= '0;
                            out_reg.entry_count <= 3'd1;
                            m_valid_reg         <= 1'b1;
                            state_reg           <= S_RESP;
                        end else begin
                            idx_reg   <= '0;
                            step_reg  <= '0;
                            state_reg <= S_SCAN;
                        end
                    end
                end

                S_SCAN: begin
                    if (step_reg != STEP_LAST) begin
                        step_reg <= step_reg + 4'd1;
                    end else if (match) begin
                        // Duplicate: refresh normal and depth only when deeper
                        out_reg.entry_count <= 3'(count_reg);
                        m_valid_reg         <= 1'b1;
                        state_reg           <= S_RESP;
                        if (deeper) begin
                            wr_reg         <= '{en: 1'b1, with_point: 1'b0, idx: idx_reg};
                            out_reg.status <= ST_DUP_UPD;
                            out_reg.slot   <= 2'(idx_reg);
                        end else begin
                            out_reg.status <= ST_DUP_KEEP;
                            out_reg.slot   <= '0;
                        end
                    end else if (!last_entry) begin
                        // Advance to the next entry, tracking the shallowest
                        wk_idx_reg   <= wk_idx_n;
                        wk_depth_reg <= wk_depth_n;
                        idx_reg      <= idx_reg + IDX_W'(1);
                        step_reg     <= '0;
                    end else begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_RESP;
                        if (count_reg < CNT_W'(CAPACITY)) begin
                            wr_reg <= '{en: 1'b1, with_point: 1'b1,
                                        idx: IDX_W'(count_reg)};
                            count_reg           <= count_reg + CNT_W'(1);
                            out_reg.status      <= ST_APPEND;
                            out_reg.slot        <= 2'(count_reg);
                            out_reg.entry_count <= 3'(count_reg + CNT_W'(1));
                        end else if (in_reg.depth > wk_depth_n) begin
                            wr_reg <= '{en: 1'b1, with_point: 1'b1, idx: wk_idx_n};
                            out_reg.status      <= ST_REPLACE;
                            out_reg.slot        <= 2'(wk_idx_n);
                            out_reg.entry_count <= 3'(count_reg);
                        end else begin
                            out_reg.status      <= ST_FULL_KEEP;
                            out_reg.slot        <= '0;
                            out_reg.entry_count <= 3'(count_reg);
                        end
                    end
                end

                S_RESP: begin
                    // Drop the table write strobe after its single cycle
                    wr_reg.en <= 1'b0;
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

endmodule

[sv/csi_checker.sv]
module csi_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input csi_pkg::in_item_t             s_data,
    input logic                          m_valid,
    input logic                          m_ready,
    input csi_pkg::out_item_t            m_data
);
    import csi_pkg::*;

    // One request in flight: no new request while a result is pending
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request taken while a result is pending");

    // A clear shows its result in the next cycle with an empty table
    a_clear_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.func == FUNC_CLEAR)) |=>
        (m_valid && (m_data.status == ST_CLEARED) && (m_data.entry_count == 3'd0)))
        else $error("clear did not give a cleared result");

    // Ready again right after the result is taken
    a_ready_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> s_ready)
        else $error("not ready after result delivery");

    // A stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

endmodule

bind contact_set_insert_core csi_checker u_csi_checker (.*);

[tb/contact_set_insert_tb_pkg.sv]
`timescale 1ns / 1ps
package contact_set_insert_tb_pkg;

    import csi_pkg::*;

    // Tracks the contact table and the results each request must produce
    class contact_table_tracker;

        entry_t             contacts[CAPACITY];
        int unsigned        used;
        logic [30:0]        min_depth;
        logic signed [31:0] normal_match_min;
        logic [31:0]        distance_sq_max;
        out_item_t          pending_results[$];
        int unsigned        mismatches;

        function new();
            used             = 0;
            min_depth        = MIN_DEPTH_RST;
            normal_match_min = NORMAL_MATCH_MIN_RST;
            distance_sq_max  = DISTANCE_SQ_MAX_RST;
            mismatches       = 0;
            foreach (contacts[i]) contacts[i] = '0;
        endfunction

        // Mirror a register write; unknown indexes are dropped
        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                CFG_MIN_DEPTH:        min_depth = data[30:0];
                CFG_NORMAL_MATCH_MIN: normal_match_min = data;
                CFG_DISTANCE_SQ_MAX:  distance_sq_max = data;
                default: ;
            endcase
        endfunction

        function logic signed [65:0] widen(logic [31:0] v);
            return {{34{v[31]}}, v};
        endfunction

        // Q2.30 dot product, floored and saturated, against the match threshold
        function bit normals_agree(entry_t e, in_item_t r);
            logic signed [65:0] acc;
            acc = widen(e.nx) * widen(r.normal_x) + widen(e.ny) * widen(r.normal_y)
                + widen(e.nz) * widen(r.normal_z);
            acc = acc >>> 30;
            if (acc > 66'sd2147483647)
                acc = 66'sd2147483647;
            else if (acc < -66'sd2147483648)
                acc = -66'sd2147483648;
            return acc > widen(normal_match_min);
        endfunction

        // Squared difference on one axis; saturate when the gap exceeds 32 bits
        function logic [67:0] axis_sq(logic [31:0] a, logic [31:0] b);
            logic signed [33:0] diff;
            logic [33:0]        mag;
            diff = {{2{a[31]}}, a} - {{2{b[31]}}, b};
            mag  = diff[33] ? -diff : diff;
            if (mag[33:32] != 2'b00)
                return '1;
            return {34'b0, mag} * {34'b0, mag};
        endfunction

        function bit points_near(entry_t e, in_item_t r);
            logic [69:0] sum;
            sum = axis_sq(e.px, r.point_x) + axis_sq(e.py, r.point_y)
                + axis_sq(e.pz, r.point_z);
            return sum < {38'b0, distance_sq_max};
        endfunction

        // Apply one request to the table and return the result it gives
        function out_item_t predict_insert(in_item_t r);
            out_item_t   res;
            status_t     st;
            int unsigned pos;
            int unsigned weakest;
            bit          seen;
            entry_t      fresh;
            pos     = 0;
            weakest = 0;
            seen    = 0;
            fresh.px    = r.point_x;
            fresh.py    = r.point_y;
            fresh.pz    = r.point_z;
            fresh.nx    = r.normal_x;
            fresh.ny    = r.normal_y;
            fresh.nz    = r.normal_z;
            fresh.depth = r.depth;
            if (r.func == FUNC_CLEAR) begin
                used = 0;
                st   = ST_CLEARED;
            end else if ($signed(r.depth) <= $signed({1'b0, min_depth})) begin
                st = ST_SHALLOW;
            end else begin
                st = ST_FULL_KEEP;
                // Scan in slot order; the first duplicate ends the scan
                for (int i = 0; i < used; i++) begin
                    if (normals_agree(contacts[i], r) && points_near(contacts[i], r)) begin
                        seen = 1;
                        if ($signed(r.depth) <= $signed(contacts[i].depth)) begin
                            st = ST_DUP_KEEP;
                        end else begin
                            contacts[i].nx    = r.normal_x;
                            contacts[i].ny    = r.normal_y;
                            contacts[i].nz    = r.normal_z;
                            contacts[i].depth = r.depth;
                            st  = ST_DUP_UPD;
                            pos = i;
                        end
                        break;
                    end
                    if ($signed(contacts[i].depth) < $signed(contacts[weakest].depth))
                        weakest = i;
                end
                // Append while there is room, else displace the shallowest entry if the offer is deeper
                if (!seen) begin
                    if (used < CAPACITY) begin
                        pos           = used;
                        contacts[pos] = fresh;
                        used++;
                        st = ST_APPEND;
                    end else if ($signed(r.depth) > $signed(contacts[weakest].depth)) begin
                        pos           = weakest;
                        contacts[pos] = fresh;
                        st = ST_REPLACE;
                    end else begin
                        st = ST_FULL_KEEP;
                    end
                end
            end
            res.status      = st;
            res.slot        = 2'(pos);
            res.entry_count = 3'(used);
            return res;
        endfunction

        function void note_request(in_item_t r);
            pending_results.push_back(predict_insert(r));
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("MISMATCH: %s", msg);
        endtask

        // Compare one result against the oldest prediction
        task check_result(out_item_t got);
            out_item_t want;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with no request pending: status=%0d slot=%0d count=%0d",
                                          got.status, got.slot, got.entry_count));
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.slot !== want.slot)
                report_mismatch($sformatf("slot got %0d want %0d", got.slot, want.slot));
            if (got.entry_count !== want.entry_count)
                report_mismatch($sformatf("entry_count got %0d want %0d",
                                          got.entry_count, want.entry_count));
        endtask

    endclass

endpackage

[tb/contact_set_insert_core_test.sv]
`timescale 1ns / 1ps
module contact_set_insert_core_test;

    import csi_pkg::*;
    import contact_set_insert_tb_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int END_CYCLES   = 60;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic signed [31:0] UNIT  = 32'sh4000_0000;
    localparam logic signed [31:0] DIAG  = 32'sd759250125;
    localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S_MIN = 32'sh8000_0000;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    contact_table_tracker tracker;

    // Scene the random requests are drawn around
    logic signed [31:0] anchors[8][3];
    logic signed [31:0] normals[4][3];
    int unsigned        point_spread = 60;
    logic [30:0]        cur_min      = MIN_DEPTH_RST;
    int unsigned        burst_left   = 0;
    bit                 hold_asked   = 1'b0;
    int unsigned        idle_cycles  = 0;

    always #5 aclk = ~aclk;

    contact_set_insert_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Note accepted requests, check results, mirror register writes
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                tracker.note_request(s_data);
            if (m_valid && m_ready)
                tracker.check_result(m_data);
            if (cfg_valid && cfg_ready)
                tracker.write_register(cfg_index, cfg_data);
        end
    end

    // End the run when no channel moves for too long
    always @(posedge aclk) begin
        if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: stall on changing patterns, with one long hold-off
    initial begin : receiver_pattern
        int unsigned mode;
        int unsigned span;
        int unsigned tick;
        bit          held;
        mode = 0;
        span = 0;
        tick = 0;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_asked && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            if (span == 0) begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(16, 160);
            end
            span--;
            tick++;
            case (mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= ($urandom_range(0, 5) == 0);
                default: m_ready <= ((tick % 7) < 4);
            endcase
        end
    end

    function automatic int wobble(int unsigned amp);
        return int'($urandom_range(0, 2 * amp)) - int'(amp);
    endfunction

    function automatic in_item_t offer(logic signed [31:0] px, logic signed [31:0] py,
                                       logic signed [31:0] pz, logic signed [31:0] nx,
                                       logic signed [31:0] ny, logic signed [31:0] nz,
                                       logic signed [31:0] d);
        in_item_t r;
        r.func     = FUNC_OFFER;
        r.point_x  = px;
        r.point_y  = py;
        r.point_z  = pz;
        r.normal_x = nx;
        r.normal_y = ny;
        r.normal_z = nz;
        r.depth    = d;
        return r;
    endfunction

    function automatic in_item_t clear_item(logic [31:0] fill);
        in_item_t r;
        r      = offer(fill, fill, fill, fill, fill, fill, fill);
        r.func = FUNC_CLEAR;
        return r;
    endfunction

    // Depth a little above the current rejection limit, clamped to the field
    function automatic logic signed [31:0] depth_above_min(int unsigned lo, int unsigned hi);
        longint v;
        v = longint'(cur_min) + longint'($urandom_range(lo, hi));
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        return v[31:0];
    endfunction

    // Mostly contacts jittered around the scene, some clears, some noise
    function automatic in_item_t random_request();
        in_item_t    r;
        int unsigned roll;
        int unsigned a;
        int unsigned k;
        int unsigned namp;
        roll = $urandom_range(0, 99);
        r = offer($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        if (roll < 4) begin
            r.func = FUNC_CLEAR;
        end else if (roll >= 14) begin
            a    = $urandom_range(0, 7);
            k    = $urandom_range(0, 3);
            namp = (roll < 60) ? 2048 : (roll < 85) ? (1 << 22) : (1 << 24);
            r.point_x  = anchors[a][0] + wobble(point_spread);
            r.point_y  = anchors[a][1] + wobble(point_spread);
            r.point_z  = anchors[a][2] + wobble(point_spread);
            r.normal_x = normals[k][0] + wobble(namp);
            r.normal_y = normals[k][1] + wobble(namp);
            r.normal_z = normals[k][2] + wobble(namp);
            case ($urandom_range(0, 9))
                0: r.depth = $urandom;
                1: r.depth = depth_above_min(0, 1);
                default: r.depth = depth_above_min(1, 3000);
            endcase
        end
        return r;
    endfunction

    // Pick anchor points (half of them close to another) and a normal set
    task automatic new_scene();
        for (int i = 0; i < 8; i++)
            for (int j = 0; j < 3; j++)
                anchors[i][j] = (i < 4) ? $urandom : anchors[i - 4][j] + wobble(3 * point_spread);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++)
                normals[i][j] = '0;
            normals[i][i] = $urandom_range(0, 1) ? UNIT : -UNIT;
        end
        normals[3][0] = DIAG;
        normals[3][1] = $urandom_range(0, 1) ? DIAG : -DIAG;
        normals[3][2] = '0;
    endtask

    // Offer one request in bursts with random gaps; hold until accepted
    task automatic send_request(in_item_t req);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic run_random(int unsigned count);
        repeat (count) send_request(random_request());
    endtask

    // Stop offering and wait until every result has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.outstanding() != 0) @(posedge aclk);
    endtask

    task automatic program_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic configure(logic [31:0] min_word, logic [31:0] match_word,
                             logic [31:0] dist_word);
        program_register(CFG_MIN_DEPTH, min_word);
        program_register(CFG_NORMAL_MATCH_MIN, match_word);
        program_register(CFG_DISTANCE_SQ_MAX, dist_word);
        cfg_valid <= 1'b0;
        cur_min = min_word[30:0];
    endtask

    initial begin : main_sequence
        localparam logic signed [31:0] AX = 32'sh0100_0000;
        localparam logic signed [31:0] AY = 32'sh0200_0000;
        localparam logic signed [31:0] AZ = -32'sh0300_0000;
        localparam logic signed [31:0] DP = 32'sh0300_0000;
        int unsigned k;
        tracker = new();
        new_scene();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests under the reset register values
        send_request(clear_item('0));
        send_request(offer(AX, AY, AZ, UNIT, 0, 0, 32'sd16));
        send_request(offer(AX, AY, AZ, UNIT, 0, 0, S_MIN));
        send_request(offer(AX, AY, AZ, UNIT, 0, 0, 32'sd100));
        send_request(offer(AX + 5, AY - 7, AZ + 3, UNIT, 0, 0, 32'sd50));
        send_request(offer(AX + 40, AY + 40, AZ + 40, UNIT - 100, 150, -80, 32'sd200));
        // same point, opposite normal: kept as its own entry
        send_request(offer(AX, AY, AZ, -UNIT, 0, 0, 32'sd300));
        send_request(offer(S_MAX, S_MIN, 0, S_MIN, 0, S_MIN, S_MAX));
        send_request(offer(-32'sh0500_0000, 0, 32'sh0900_0000, 0, UNIT, 0, 32'sd400));
        // full table: not deeper, then displace the shallowest, then a tie
        send_request(offer(DP, DP, DP, 0, UNIT, 0, 32'sd150));
        send_request(offer(DP, DP, DP, 0, UNIT, 0, 32'sd250));
        send_request(offer(-32'sh0100_0000, -32'sh0100_0000, 0, 0, 0, UNIT, 32'sd300));
        send_request(offer(0, 32'sh0500_0000, 0, 0, 0, UNIT, 32'sd350));
        // dot product saturating high, then low
        send_request(offer(S_MAX, S_MIN, 0, S_MIN, S_MIN, S_MIN, 32'sd1000));
        send_request(offer(S_MAX, S_MIN, 0, S_MAX, S_MAX, S_MAX, 32'sd2000));
        send_request(clear_item('1));
        send_request(offer(S_MIN, S_MAX, S_MIN, 0, 0, -UNIT, S_MAX));
        run_random(160);
        drain();

        // Normals match unless the dot product saturates low; wide radius, depth floor at zero
        configure(32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
        point_spread = 40000;
        new_scene();
        run_random(150);
        drain();

        // Reject every offer; also poke the unused register index
        program_register(CFG_UNUSED, $urandom);
        configure(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000);
        point_spread = 60;
        new_scene();
        run_random(60);
        drain();

        // Random settings around typical thresholds
        for (int p = 0; p < 5; p++) begin
            k = $urandom_range(4, 11);
            configure({1'($urandom_range(0, 1)), 31'($urandom_range(0, 4096))},
                      UNIT - $urandom_range(0, 1 << 17),
                      $urandom_range(1 << (2 * k - 1), 1 << (2 * k + 1)));
            point_spread = 1 << k;
            new_scene();
            if (p == 0)
                hold_asked = 1'b1;
            run_random(180);
            drain();
        end

        repeat (END_CYCLES) @(posedge aclk);
        if (tracker.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
sv/csi_pkg.sv
sv/csi_table.sv
sv/csi_mac.sv
sv/contact_set_insert_core.sv
sv/csi_checker.sv
tb/contact_set_insert_tb_pkg.sv
tb/contact_set_insert_core_test.sv
